### rtl/tme_pkg.sv
package tme_pkg;

    // Command kinds.
    localparam logic [2:0] K_SHOW = 3'd0;
    localparam logic [2:0] K_LOAD = 3'd1;
    localparam logic [2:0] K_MOVE = 3'd2;
    localparam logic [2:0] K_ADD  = 3'd3;
    localparam logic [2:0] K_SUB  = 3'd4;
    localparam logic [2:0] K_MUL  = 3'd5;
    localparam logic [2:0] K_DIV  = 3'd6;
    localparam logic [2:0] K_MOD  = 3'd7;

    // Operand spaces.
    localparam logic [1:0] SP_REG  = 2'd0;
    localparam logic [1:0] SP_MEM  = 2'd1;
    localparam logic [1:0] SP_FLAG = 2'd2;

    // Flag bit positions and the highest flag index.
    localparam int FLG_Z = 0;
    localparam int FLG_S = 1;
    localparam int FLG_O = 2;
    localparam logic [2:0] FLAG_MAX = 3'd2;

    localparam int NUM_REGS_DEF  = 4;
    localparam int NUM_CELLS_DEF = 8;

    // Location store: address is {space bit, index}, entry is {defined, value}.
    localparam int LOC_AW    = 4;
    localparam int LOC_DEPTH = 16;
    localparam int CELL_W    = 9;

    localparam int DIV_STEPS = 8;

    // Microprogram jump conditions.
    localparam logic [3:0] C_NEXT     = 4'd0;
    localparam logic [3:0] C_ALWAYS   = 4'd1;
    localparam logic [3:0] C_NO_CMD   = 4'd2;
    localparam logic [3:0] C_ILLEGAL  = 4'd3;
    localparam logic [3:0] C_SHOW     = 4'd4;
    localparam logic [3:0] C_LOAD     = 4'd5;
    localparam logic [3:0] C_MOVE     = 4'd6;
    localparam logic [3:0] C_BUSY     = 4'd7;
    localparam logic [3:0] C_OUT_FULL = 4'd8;

    // Write selections.
    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_ARITH = 2'd1;
    localparam logic [1:0] WR_LOAD  = 2'd2;
    localparam logic [1:0] WR_MOVE  = 2'd3;

    // Microprogram step addresses.
    localparam logic [3:0] S_WAIT   = 4'd0;
    localparam logic [3:0] S_RDA    = 4'd1;
    localparam logic [3:0] S_RDB    = 4'd2;
    localparam logic [3:0] S_LATB   = 4'd3;
    localparam logic [3:0] S_TLOAD  = 4'd4;
    localparam logic [3:0] S_TMOVE  = 4'd5;
    localparam logic [3:0] S_ALU    = 4'd6;
    localparam logic [3:0] S_ALUW   = 4'd7;
    localparam logic [3:0] S_WARITH = 4'd8;
    localparam logic [3:0] S_WLOAD  = 4'd9;
    localparam logic [3:0] S_WMOVE  = 4'd10;
    localparam logic [3:0] S_REJ    = 4'd11;
    localparam logic [3:0] S_SHOW   = 4'd14;
    localparam logic [3:0] S_OUT    = 4'd15;

    typedef struct packed {
        logic [2:0]        kind;
        logic [1:0]        first_space;
        logic [2:0]        first_index;
        logic              second_space;
        logic [2:0]        second_index;
        logic signed [15:0] immediate;
    } cmd_t;

    typedef struct packed {
        logic              status;
        logic signed [7:0] shown_value;
        logic              shown_defined;
        logic              zero_flag;
        logic              sign_flag;
        logic              overflow_flag;
    } rsp_t;

    typedef struct packed {
        logic       cap;
        logic       rd_b;
        logic       lat_a;
        logic       lat_b;
        logic       alu_start;
        logic [1:0] wr;
        logic       set_rej;
        logic       set_show;
        logic       emit;
        logic [3:0] cond;
        logic [3:0] target;
    } uword_t;

    typedef struct packed {
        logic cmd_valid;
        logic illegal;
        logic is_show;
        logic is_load;
        logic is_move;
        logic alu_busy;
        logic out_full;
    } cond_t;

    // Control store. A step whose condition fails goes to the next address;
    // the output step sits at the last address so that it wraps to the wait step.
    function automatic uword_t ucode(input logic [3:0] step);
        uword_t uw;
        uw = '0;
        unique case (step)
            S_WAIT:
            begin
                uw.cap    = 1'b1;
                uw.cond   = C_NO_CMD;
                uw.target = S_WAIT;
            end
            S_RDA:
            begin
                uw.cond   = C_ILLEGAL;
                uw.target = S_REJ;
            end
            S_RDB:
            begin
                uw.rd_b  = 1'b1;
                uw.lat_a = 1'b1;
            end
            S_LATB:
            begin
                uw.lat_b  = 1'b1;
                uw.cond   = C_SHOW;
                uw.target = S_SHOW;
            end
            S_TLOAD:
            begin
                uw.cond   = C_LOAD;
                uw.target = S_WLOAD;
            end
            S_TMOVE:
            begin
                uw.cond   = C_MOVE;
                uw.target = S_WMOVE;
            end
            S_ALU:
            begin
                uw.alu_start = 1'b1;
            end
            S_ALUW:
            begin
                uw.cond   = C_BUSY;
                uw.target = S_ALUW;
            end
            S_WARITH:
            begin
                uw.wr     = WR_ARITH;
                uw.cond   = C_ALWAYS;
                uw.target = S_OUT;
            end
            S_WLOAD:
            begin
                uw.wr     = WR_LOAD;
                uw.cond   = C_ALWAYS;
                uw.target = S_OUT;
            end
            S_WMOVE:
            begin
                uw.wr     = WR_MOVE;
                uw.cond   = C_ALWAYS;
                uw.target = S_OUT;
            end
            S_REJ:
            begin
                uw.set_rej = 1'b1;
                uw.cond    = C_ALWAYS;
                uw.target  = S_OUT;
            end
            S_SHOW:
            begin
                uw.set_show = 1'b1;
            end
            S_OUT:
            begin
                uw.emit   = 1'b1;
                uw.cond   = C_OUT_FULL;
                uw.target = S_OUT;
            end
            default:
            begin
                uw.cond   = C_ALWAYS;
                uw.target = S_WAIT;
            end
        endcase
        return uw;
    endfunction

endpackage

### rtl/tme_ram.sv
module tme_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tme_alu.sv
module tme_alu (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] op,
    input  logic [8:0] a,
    input  logic [8:0] b,
    output logic       busy,
    output logic       ok,
    output logic [7:0] value
);

    logic signed [15:0] x_wide;
    logic signed [15:0] y_wide;
    logic               is_div;
    logic [7:0]         a_mag;
    logic [7:0]         b_mag;

    logic [2:0]  op_reg;
    logic        def_reg;
    logic [15:0] wide_reg;
    logic [7:0]  q_reg;
    logic [7:0]  r_reg;
    logic [7:0]  d_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;

    logic [8:0]  trial;
    logic        fit;
    logic [8:0]  trial_sub;
    logic [15:0] res;

    assign x_wide = 16'(signed'(a[7:0]));
    assign y_wide = 16'(signed'(b[7:0]));
    assign is_div = (op == tme_pkg::K_DIV) || (op == tme_pkg::K_MOD);
    assign a_mag  = a[7] ? 8'(-a[7:0]) : a[7:0];
    assign b_mag  = b[7] ? 8'(-b[7:0]) : b[7:0];

    // One restoring division step per cycle on the magnitudes.
    assign trial     = {r_reg, q_reg[7]};
    assign fit       = (trial >= {1'b0, d_reg});
    assign trial_sub = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= is_div;
            cnt_reg  <= 4'(tme_pkg::DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg    <= op;
            def_reg   <= a[8] && b[8] && !(is_div && (b[7:0] == 8'd0));
            neg_q_reg <= a[7] ^ b[7];
            neg_r_reg <= a[7];
            q_reg     <= a_mag;
            r_reg     <= '0;
            d_reg     <= b_mag;
            unique case (op)
                tme_pkg::K_SUB: wide_reg <= y_wide - x_wide;
                tme_pkg::K_MUL: wide_reg <= x_wide * y_wide;
                default:        wide_reg <= x_wide + y_wide;
            endcase
        end
        else if (busy_reg)
        begin
            r_reg <= fit ? trial_sub[7:0] : trial[7:0];
            q_reg <= {q_reg[6:0], fit};
        end
    end

    always_comb
    begin
        unique case (op_reg)
            tme_pkg::K_DIV: res = neg_q_reg ? 16'(0) - {8'd0, q_reg} : {8'd0, q_reg};
            tme_pkg::K_MOD: res = neg_r_reg ? 16'(0) - {8'd0, r_reg} : {8'd0, r_reg};
            default:        res = wide_reg;
        endcase
    end

    assign busy  = busy_reg;
    assign ok    = def_reg && ((res[15:7] == 9'h000) || (res[15:7] == 9'h1FF));
    assign value = res[7:0];

endmodule

### rtl/tme_seq.sv
module tme_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  tme_pkg::cond_t  cond,
    output tme_pkg::uword_t uw
);

    logic [3:0]      pc_reg;
    logic [3:0]      pc_next;
    tme_pkg::uword_t uw_cur;
    logic            jump;

    assign uw_cur = tme_pkg::ucode(pc_reg);

    always_comb
    begin
        unique case (uw_cur.cond)
            tme_pkg::C_NEXT:     jump = 1'b0;
            tme_pkg::C_ALWAYS:   jump = 1'b1;
            tme_pkg::C_NO_CMD:   jump = !cond.cmd_valid;
            tme_pkg::C_ILLEGAL:  jump = cond.illegal;
            tme_pkg::C_SHOW:     jump = cond.is_show;
            tme_pkg::C_LOAD:     jump = cond.is_load;
            tme_pkg::C_MOVE:     jump = cond.is_move;
            tme_pkg::C_BUSY:     jump = cond.alu_busy;
            tme_pkg::C_OUT_FULL: jump = cond.out_full;
            default:             jump = 1'b1;
        endcase
        pc_next = jump ? uw_cur.target : pc_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= tme_pkg::S_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign uw = uw_cur;

endmodule

### rtl/tiny_machine_execute.sv
// One command is handled at a time: the microprogram takes no new command until the
// response of the last one has been registered, and a stalled response holds it longer.
// A rejected command takes the shortest path through the microprogram, and div and mod,
// with the 8-step divider loop, take the longest.
// Reset: registers and memory cells read as undefined and the flags clear at once.
module tiny_machine_execute #(
    parameter int NUM_REGS  = tme_pkg::NUM_REGS_DEF,
    parameter int NUM_CELLS = tme_pkg::NUM_CELLS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  tme_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tme_pkg::rsp_t rsp
);

    localparam int AW = tme_pkg::LOC_AW;
    localparam int CW = tme_pkg::CELL_W;

    tme_pkg::uword_t uw;
    tme_pkg::cond_t  cond;

    tme_pkg::cmd_t   cmd_reg;
    logic [CW-1:0]   opa_reg;
    logic [CW-1:0]   opb_reg;
    logic [2:0]      flag_reg;
    logic [2:0]      flag_next;
    logic [tme_pkg::LOC_DEPTH-1:0] vld_reg;
    logic            rd_vld_reg;
    logic            rej_reg;
    logic [7:0]      shown_reg;
    logic            shown_def_reg;
    logic            rsp_valid_reg;
    tme_pkg::rsp_t   rsp_reg;

    logic [AW-1:0]   addr_a;
    logic [AW-1:0]   addr_b;
    logic [AW-1:0]   raddr;
    logic [CW-1:0]   rdata;
    logic [CW-1:0]   rd_eff;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [CW-1:0]   wdata;

    logic            a_reg_ok;
    logic            a_mem_ok;
    logic            b_reg_ok;
    logic            b_mem_ok;
    logic            a_ok;
    logic            b_ok;
    logic            b_is_mem;
    logic            illegal;
    logic            imm_fits;
    logic [3:0]      flag_ext;

    logic            alu_busy;
    logic            alu_ok;
    logic [7:0]      alu_val;
    logic            out_full;
    logic            take;

    assign addr_a   = {cmd_reg.first_space[0], cmd_reg.first_index};
    assign addr_b   = {cmd_reg.second_space, cmd_reg.second_index};
    assign b_is_mem = ({1'b0, cmd_reg.second_space} == tme_pkg::SP_MEM);

    assign a_reg_ok = ({1'b0, cmd_reg.first_index} < 4'(NUM_REGS));
    assign a_mem_ok = ({1'b0, cmd_reg.first_index} < 4'(NUM_CELLS));
    assign b_reg_ok = ({1'b0, cmd_reg.second_index} < 4'(NUM_REGS));
    assign b_mem_ok = ({1'b0, cmd_reg.second_index} < 4'(NUM_CELLS));
    assign a_ok = ((cmd_reg.first_space == tme_pkg::SP_REG) && a_reg_ok)
               || ((cmd_reg.first_space == tme_pkg::SP_MEM) && a_mem_ok);
    assign b_ok = b_is_mem ? b_mem_ok : b_reg_ok;

    always_comb
    begin
        priority if (cmd_reg.kind == tme_pkg::K_SHOW)
        begin
            if (cmd_reg.first_space == tme_pkg::SP_FLAG)
            begin
                illegal = (cmd_reg.first_index > tme_pkg::FLAG_MAX);
            end
            else
            begin
                illegal = !a_ok;
            end
        end
        else if (cmd_reg.kind == tme_pkg::K_LOAD)
        begin
            illegal = !b_ok;
        end
        else
        begin
            illegal = !a_ok || !b_ok
                   || ((cmd_reg.first_space == tme_pkg::SP_MEM) && b_is_mem);
        end
    end

    assign imm_fits = (cmd_reg.immediate[15:7] == 9'h000)
                   || (cmd_reg.immediate[15:7] == 9'h1FF);

    assign out_full = rsp_valid_reg && rsp_stall;
    assign take     = uw.cap && cmd_valid;

    assign cond.cmd_valid = cmd_valid;
    assign cond.illegal   = illegal;
    assign cond.is_show   = (cmd_reg.kind == tme_pkg::K_SHOW);
    assign cond.is_load   = (cmd_reg.kind == tme_pkg::K_LOAD);
    assign cond.is_move   = (cmd_reg.kind == tme_pkg::K_MOVE);
    assign cond.alu_busy  = alu_busy;
    assign cond.out_full  = out_full;

    tme_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .uw    (uw)
    );

    // The store holds registers in the lower half and memory cells in the upper.
    assign raddr = uw.rd_b ? addr_b : addr_a;

    tme_ram #(
        .WIDTH (CW),
        .DEPTH (tme_pkg::LOC_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // A location never written since reset reads as undefined.
    assign rd_eff = rd_vld_reg ? rdata : '0;

    tme_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (uw.alu_start),
        .op    (cmd_reg.kind),
        .a     (opa_reg),
        .b     (opb_reg),
        .busy  (alu_busy),
        .ok    (alu_ok),
        .value (alu_val)
    );

    always_comb
    begin
        we        = 1'b0;
        waddr     = addr_b;
        wdata     = opa_reg;
        flag_next = flag_reg;
        unique case (uw.wr)
            tme_pkg::WR_ARITH:
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = alu_ok ? {1'b1, alu_val} : '0;
                if (alu_ok)
                begin
                    flag_next = {1'b0, alu_val[7], (alu_val == 8'd0)};
                end
                else
                begin
                    flag_next = 3'b100;
                end
            end
            tme_pkg::WR_LOAD:
            begin
                we    = 1'b1;
                wdata = imm_fits ? {1'b1, cmd_reg.immediate[7:0]} : '0;
                if (!imm_fits)
                begin
                    flag_next[tme_pkg::FLG_O] = 1'b1;
                end
            end
            tme_pkg::WR_MOVE:
            begin
                we = 1'b1;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign flag_ext = {1'b0, flag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= '0;
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (uw.emit && !out_full)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_vld_reg <= vld_reg[raddr];
        if (take)
        begin
            cmd_reg       <= cmd;
            rej_reg       <= 1'b0;
            shown_reg     <= '0;
            shown_def_reg <= 1'b0;
        end
        if (uw.lat_a)
        begin
            opa_reg <= rd_eff;
        end
        if (uw.lat_b)
        begin
            opb_reg <= rd_eff;
        end
        if (uw.set_rej)
        begin
            rej_reg <= 1'b1;
        end
        if (uw.set_show)
        begin
            if (cmd_reg.first_space == tme_pkg::SP_FLAG)
            begin
                shown_reg     <= {7'd0, flag_ext[cmd_reg.first_index[1:0]]};
                shown_def_reg <= 1'b1;
            end
            else
            begin
                shown_reg     <= opa_reg[8] ? opa_reg[7:0] : 8'd0;
                shown_def_reg <= opa_reg[8];
            end
        end
        if (uw.emit && !out_full)
        begin
            rsp_reg.status        <= rej_reg;
            rsp_reg.shown_value   <= shown_reg;
            rsp_reg.shown_defined <= shown_def_reg;
            rsp_reg.zero_flag     <= flag_reg[tme_pkg::FLG_Z];
            rsp_reg.sign_flag     <= flag_reg[tme_pkg::FLG_S];
            rsp_reg.overflow_flag <= flag_reg[tme_pkg::FLG_O];
        end
    end

    assign cmd_stall = !uw.cap;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // After a command transfer no further command is taken until it is answered.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("command taken while the previous one is in progress");

    // The result is written to register 0 only once the divider has finished.
    a_write_after_alu: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.wr == tme_pkg::WR_ARITH) |-> !alu_busy)
        else $error("arithmetic result written while the divider is running");

    // A rejected command shows nothing.
    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |-> (rsp.shown_value == 8'sd0 && !rsp.shown_defined))
        else $error("rejected command shows a value");

    // An undefined or absent show reports a zero value.
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.shown_defined) |-> (rsp.shown_value == 8'sd0))
        else $error("undefined show reports a nonzero value");
`endif

endmodule
